FILE: rtl/single_button_dimmer_control_assert.svh
// Assertion macros shared by the dimmer control RTL.
`ifndef SINGLE_BUTTON_DIMMER_CONTROL_ASSERT_SVH
`define SINGLE_BUTTON_DIMMER_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS

`define SBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbd: same-cycle check failed");

`define SBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbd: next-cycle check failed");

`else

`define SBD_ASSERT_SAME(label, ante, cons)

`define SBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/sbd_pkg.sv
// Types, register indexes and reset values for the dimmer control.
`default_nettype none

package sbd_pkg;

    localparam int TickWidth  = 8;
    localparam int UnitWidth  = 8;
    localparam int DutyWidth  = 7;
    localparam int IndexWidth = 3;
    localparam int DataWidth  = 8;

    localparam logic [IndexWidth-1:0] RegDebounceTicks   = 3'd0;
    localparam logic [IndexWidth-1:0] RegLongPressUnits  = 3'd1;
    localparam logic [IndexWidth-1:0] RegShortPressLimit = 3'd2;
    localparam logic [IndexWidth-1:0] RegFullDuty        = 3'd3;

    localparam logic [TickWidth-1:0] DebounceTicksReset   = 8'd4;
    localparam logic [UnitWidth-1:0] LongPressUnitsReset  = 8'd15;
    localparam logic [UnitWidth-1:0] ShortPressLimitReset = 8'd10;
    localparam logic [DutyWidth-1:0] FullDutyReset        = 7'd100;

    localparam logic [UnitWidth-1:0] PressUnitsMax = 8'd255;

    typedef struct packed {
        logic [TickWidth-1:0] debounce_ticks;
        logic [UnitWidth-1:0] long_press_units;
        logic [UnitWidth-1:0] short_press_limit;
        logic [DutyWidth-1:0] full_duty;
    } sbd_cfg_t;

    typedef struct packed {
        logic [TickWidth-1:0] tick_count;
        logic [UnitWidth-1:0] press_units;
        logic                 long_press_seen;
        logic                 ramp_down;
        logic [DutyWidth-1:0] duty_now;
        logic [DutyWidth-1:0] duty_saved;
        logic                 on_status;
        logic                 report_pending;
    } sbd_state_t;

    typedef struct packed {
        logic [DutyWidth-1:0] duty_level;
        logic                 light_on;
        logic                 report_valid;
    } sbd_result_t;

endpackage

`default_nettype wire

FILE: rtl/sbd_core.sv
// Dimmer state registers and the per-tick press, ramp and toggle logic.
`default_nettype none
`include "single_button_dimmer_control_assert.svh"

module sbd_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic                button,
    input  sbd_pkg::sbd_cfg_t        cfg,
    output sbd_pkg::sbd_result_t     result
);
    import sbd_pkg::*;

    sbd_state_t           st_reg;
    sbd_state_t           st_next;
    logic [TickWidth-1:0] tick_inc;
    logic                 short_hit;
    logic                 report;

    assign tick_inc  = st_reg.tick_count + 8'd1;
    assign short_hit = !st_reg.long_press_seen && (st_reg.press_units != '0)
                       && (st_reg.press_units < cfg.short_press_limit);

    always_comb
    begin
        st_next = st_reg;
        report  = 1'b0;
        if (in_fire)
        begin
            if (button)
            begin
                if (tick_inc <= cfg.debounce_ticks)
                begin
                    st_next.tick_count = tick_inc;
                end
                else
                begin
                    st_next.tick_count = '0;
                    if (st_reg.press_units != PressUnitsMax)
                    begin
                        st_next.press_units = st_reg.press_units + 8'd1;
                    end
                    if (st_next.press_units > cfg.long_press_units)
                    begin
                        st_next.long_press_seen = 1'b1;
                        if (!st_reg.ramp_down)
                        begin
                            if (st_reg.duty_now < cfg.full_duty)
                            begin
                                st_next.duty_now       = st_reg.duty_now + 7'd1;
                                st_next.duty_saved     = st_reg.duty_now + 7'd1;
                                st_next.report_pending = 1'b1;
                            end
                        end
                        else if (st_reg.duty_now != '0)
                        begin
                            st_next.duty_now       = st_reg.duty_now - 7'd1;
                            st_next.duty_saved     = st_reg.duty_now - 7'd1;
                            st_next.report_pending = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                if (short_hit)
                begin
                    st_next.report_pending = 1'b1;
                    if (st_reg.duty_now != '0)
                    begin
                        st_next.duty_saved = st_reg.duty_now;
                        st_next.duty_now   = '0;
                        st_next.on_status  = 1'b0;
                    end
                    else
                    begin
                        if (st_reg.duty_saved == '0)
                        begin
                            st_next.duty_now   = cfg.full_duty;
                            st_next.duty_saved = cfg.full_duty;
                        end
                        else
                        begin
                            st_next.duty_now = st_reg.duty_saved;
                        end
                        st_next.on_status = 1'b1;
                    end
                end
                else if (st_reg.long_press_seen)
                begin
                    st_next.ramp_down = !st_reg.ramp_down;
                end
                if (st_next.duty_now == '0)
                begin
                    st_next.ramp_down = 1'b0;
                end
                if (st_next.duty_now == cfg.full_duty)
                begin
                    st_next.ramp_down = 1'b1;
                end
                st_next.tick_count      = '0;
                st_next.press_units     = '0;
                st_next.long_press_seen = 1'b0;
                report                  = st_next.report_pending;
                st_next.report_pending  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign result.duty_level   = st_next.duty_now;
    assign result.light_on     = st_next.on_status;
    assign result.report_valid = report;

    `SBD_ASSERT_NEXT(a_release_clears, in_fire && !button, (st_reg.tick_count == '0) && (st_reg.press_units == '0) && !st_reg.long_press_seen && !st_reg.report_pending)
    `SBD_ASSERT_NEXT(a_units_no_drop, in_fire && button, st_reg.press_units >= $past(st_reg.press_units))
    `SBD_ASSERT_NEXT(a_duty_one_step, in_fire && button, (st_reg.duty_now == $past(st_reg.duty_now)) || (st_reg.duty_now == $past(st_reg.duty_now) + 7'd1) || (st_reg.duty_now + 7'd1 == $past(st_reg.duty_now)))
    `SBD_ASSERT_NEXT(a_full_ramps_down, in_fire && !button, (st_reg.duty_now != $past(cfg.full_duty)) || st_reg.ramp_down)

endmodule

`default_nettype wire

FILE: rtl/single_button_dimmer_control.sv
// Top level of the single-button dimmer: config registers, core and output skid buffer.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, button_pressed           | sink
//  out     | out_valid, out_ready, duty_level, light_on,  | source
//          | report_valid                                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | sink
//
// One tick sample per clock while in_ready is high; the result is registered.
// The whole tick update is one combinational pass from the state registers.
// A two-entry output buffer (output register plus skid) keeps input flowing
// while a result waits; in_ready drops only when both entries are full.
// Reset clears core state and valid flags, loads register defaults; cfg_ready stays high.
`default_nettype none
`include "single_button_dimmer_control_assert.svh"

module single_button_dimmer_control (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output      logic                            in_ready,
    input  wire logic                            button_pressed,
    output      logic                            out_valid,
    input  wire logic                            out_ready,
    output      logic [sbd_pkg::DutyWidth-1:0]   duty_level,
    output      logic                            light_on,
    output      logic                            report_valid,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [sbd_pkg::IndexWidth-1:0]  cfg_index,
    input  wire logic [sbd_pkg::DataWidth-1:0]   cfg_data
);
    import sbd_pkg::*;

    sbd_cfg_t    cfg_reg;
    sbd_result_t core_result;
    sbd_result_t out_reg;
    sbd_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        in_fire;
    logic        out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_load  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks    <= DebounceTicksReset;
            cfg_reg.long_press_units  <= LongPressUnitsReset;
            cfg_reg.short_press_limit <= ShortPressLimitReset;
            cfg_reg.full_duty         <= FullDutyReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                RegDebounceTicks:   cfg_reg.debounce_ticks    <= cfg_data;
                RegLongPressUnits:  cfg_reg.long_press_units  <= cfg_data;
                RegShortPressLimit: cfg_reg.short_press_limit <= cfg_data;
                RegFullDuty:        cfg_reg.full_duty         <= cfg_data[DutyWidth-1:0];
                default:            ;
            endcase
        end
    end

    sbd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .button  (button_pressed),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // advance the output register from the skid entry first, else from the core
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= skid_valid_reg || in_fire;
                skid_valid_reg <= 1'b0;
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= skid_valid_reg ? skid_reg : core_result;
        end
        if (in_fire && !out_load)
        begin
            skid_reg <= core_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_level   = out_reg.duty_level;
    assign light_on     = out_reg.light_on;
    assign report_valid = out_reg.report_valid;

    `SBD_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `SBD_ASSERT_NEXT(a_fire_fills_out, in_fire && !out_valid_reg, out_valid_reg)
    `SBD_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_valid_reg && !out_ready, skid_valid_reg)

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the single-button dimmer control: stimulus, predictor and checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbd_pkg::*;

    localparam int ClkPeriod  = 10;
    localparam int CycleLimit = 200000;
    localparam int HoldCap    = 700;
    localparam int DrainSlack = 4;

    localparam logic [IndexWidth-1:0] RegFirstSpare = RegFullDuty + 1'b1;
    localparam logic [IndexWidth-1:0] RegLastSpare  = '1;

    class dimmer_scoreboard;
        bit [TickWidth-1:0] deb_ticks;
        bit [UnitWidth-1:0] long_units;
        bit [UnitWidth-1:0] short_limit;
        bit [DutyWidth-1:0] full_level;

        bit [TickWidth-1:0] held_ticks;
        bit [UnitWidth-1:0] units;
        bit                 long_hit;
        bit                 ramping_down;
        bit [DutyWidth-1:0] duty;
        bit [DutyWidth-1:0] duty_memo;
        bit                 lit;
        bit                 report_owed;

        sbd_result_t predicted_levels[$];
        int          errors;

        function new();
            deb_ticks    = DebounceTicksReset;
            long_units   = LongPressUnitsReset;
            short_limit  = ShortPressLimitReset;
            full_level   = FullDutyReset;
            held_ticks   = '0;
            units        = '0;
            long_hit     = 1'b0;
            ramping_down = 1'b0;
            duty         = '0;
            duty_memo    = '0;
            lit          = 1'b0;
            report_owed  = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(logic [IndexWidth-1:0] idx, logic [DataWidth-1:0] data);
            case (idx)
                RegDebounceTicks:   deb_ticks   = data;
                RegLongPressUnits:  long_units  = data;
                RegShortPressLimit: short_limit = data;
                RegFullDuty:        full_level  = data[DutyWidth-1:0];
                default: ;
            endcase
        endfunction

        function void count_hold();
            held_ticks = held_ticks + 1'b1;
            if (held_ticks <= deb_ticks)
                return;
            held_ticks = '0;
            if (units != PressUnitsMax)
                units = units + 1'b1;
            if (units <= long_units)
                return;
            long_hit = 1'b1;
            if (!ramping_down) begin
                if (duty < full_level) begin
                    duty        = duty + 1'b1;
                    duty_memo   = duty;
                    report_owed = 1'b1;
                end
            end else if (duty != '0) begin
                duty        = duty - 1'b1;
                duty_memo   = duty;
                report_owed = 1'b1;
            end
        endfunction

        function bit apply_release();
            bit flush;
            flush = 1'b0;
            if (!long_hit && units != '0 && units < short_limit) begin
                report_owed = 1'b1;
                if (duty != '0) begin
                    duty_memo = duty;
                    duty      = '0;
                    lit       = 1'b0;
                end else begin
                    duty = duty_memo;
                    if (duty == '0) begin
                        duty      = full_level;
                        duty_memo = duty;
                    end
                    lit = 1'b1;
                end
            end else if (long_hit) begin
                ramping_down = !ramping_down;
            end
            if (duty == '0)
                ramping_down = 1'b0;
            if (duty == full_level)
                ramping_down = 1'b1;
            held_ticks = '0;
            units      = '0;
            long_hit   = 1'b0;
            if (report_owed) begin
                report_owed = 1'b0;
                flush       = 1'b1;
            end
            return flush;
        endfunction

        function void note_tick(logic pressed);
            sbd_result_t r;
            r.report_valid = 1'b0;
            if (pressed)
                count_hold();
            else
                r.report_valid = apply_release();
            r.duty_level = duty;
            r.light_on   = lit;
            predicted_levels.push_back(r);
        endfunction

        function void check_result(sbd_result_t got);
            sbd_result_t want;
            if (predicted_levels.size() == 0) begin
                $error("result transfer with no tick outstanding");
                errors++;
                return;
            end
            want = predicted_levels.pop_front();
            if (got.duty_level !== want.duty_level) begin
                $error("duty_level: expected %0d, actual %0d", want.duty_level, got.duty_level);
                errors++;
            end
            if (got.light_on !== want.light_on) begin
                $error("light_on: expected %0b, actual %0b", want.light_on, got.light_on);
                errors++;
            end
            if (got.report_valid !== want.report_valid) begin
                $error("report_valid: expected %0b, actual %0b",
                       want.report_valid, got.report_valid);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_levels.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  button_pressed;
    logic                  out_valid;
    logic                  out_ready;
    logic [DutyWidth-1:0]  duty_level;
    logic                  light_on;
    logic                  report_valid;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IndexWidth-1:0] cfg_index;
    logic [DataWidth-1:0]  cfg_data;

    dimmer_scoreboard board;
    int               in_idle_pct;
    int               out_idle_pct;
    int               ticks_sent;
    int               cycles;

    single_button_dimmer_control dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duty_level     (duty_level),
        .light_on       (light_on),
        .report_valid   (report_valid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(ClkPeriod / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({duty_level, light_on, report_valid});
    end

    task automatic send_tick(input logic pressed);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        button_pressed <= pressed;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_tick(pressed);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic press(input int hold, input int rest);
        repeat (hold) send_tick(1'b1);
        repeat (rest) send_tick(1'b0);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
    endtask

    task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [DataWidth-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [DataWidth-1:0] deb, input logic [DataWidth-1:0] lp,
                                 input logic [DataWidth-1:0] spl, input logic [DataWidth-1:0] fd);
        wait_drained();
        write_reg(RegDebounceTicks, deb);
        write_reg(RegLongPressUnits, lp);
        write_reg(RegShortPressLimit, spl);
        write_reg(RegFullDuty, fd);
        write_reg(logic'($urandom_range(RegFirstSpare, RegLastSpare)) ?
                  IndexWidth'($urandom_range(RegFirstSpare, RegLastSpare)) : RegLastSpare,
                  DataWidth'($urandom));
    endtask

    task automatic random_burst(input int budget);
        int pick;
        int units;
        int hold;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            send_tick(logic'($urandom_range(0, 1)));
            return;
        end
        if (pick < 55)
            units = $urandom_range(0, board.short_limit + 1);
        else if (pick < 90)
            units = board.long_units + $urandom_range(0, 12);
        else
            units = $urandom_range(0, 270);
        hold = units * (board.deb_ticks + 1) + $urandom_range(0, board.deb_ticks);
        if (hold > HoldCap)
            hold = HoldCap;
        if (hold > budget)
            hold = budget;
        press(hold, $urandom_range(1, 3));
    endtask

    task automatic run_phase(input logic [DataWidth-1:0] deb, input logic [DataWidth-1:0] lp,
                             input logic [DataWidth-1:0] spl, input logic [DataWidth-1:0] fd,
                             input int count, input int idle_pct);
        int start;
        load_settings(deb, lp, spl, fd);
        in_idle_pct  = idle_pct;
        out_idle_pct = idle_pct;
        start        = ticks_sent;
        while (ticks_sent - start < count)
            random_burst(count - (ticks_sent - start));
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        button_pressed = 1'b0;
        out_ready      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_idle_pct    = 35;
        out_idle_pct   = 35;
        ticks_sent     = 0;
        cycles         = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short presses toggle, long holds ramp down to zero and back up
        load_settings(8'd0, 8'd3, 8'd3, 8'd3);
        press(0, 1);
        press(1, 1);
        press(1, 1);
        press(1, 1);
        press(3, 1);
        press(7, 1);
        press(5, 1);
        press(2, 1);

        run_phase(8'd1, 8'd3, 8'd4, 8'd10, 200, 35);
        run_phase(8'd0, 8'd0, 8'd255, 8'd127, 100, 0);
        run_phase(8'd1, 8'd2, 8'd6, 8'h85, 150, 35);
        run_phase(8'd2, 8'd4, 8'd1, 8'd6, 150, 35);
        run_phase(8'd0, 8'd5, 8'd4, 8'h80, 100, 35);
        run_phase(8'd255, 8'd255, 8'd0, 8'd1, 300, 35);
        run_phase(8'd0, 8'd255, 8'd255, 8'hFF, 300, 35);

        wait_drained();
        repeat (DrainSlack) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
